FILE: hw/rtl/asid_pkg.sv
// Shared widths, operation codes and status codes of the array search, insert and delete core.
package asid_pkg;

   localparam int unsigned CAPACITY_DEF = 64;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned VAL_W    = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned INDEX_W  = 6;
   localparam int unsigned COUNT_W  = 7;

   typedef enum logic [OP_W-1:0] {
      OP_LINEAR = 2'd0,
      OP_BINARY = 2'd1,
      OP_INSERT = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

endpackage

FILE: hw/rtl/array_search_insert_delete_core.sv
// Ordered list in a synchronous memory: linear and binary search, insert and delete.
// Insert shifts the entries from the position onward up one slot, then writes the new value;
// delete shifts the entries after the position down one slot; a full list or a bad position
// is answered without a memory access.
// One request at a time; the linear search and the shifts read one entry a cycle.
// The result sits in an output register, so the next request is taken while it waits.
// Synchronous reset empties the list (count zero); memory contents are not cleared.
module array_search_insert_delete_core #(
   parameter int unsigned CAPACITY = asid_pkg::CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [asid_pkg::OP_W-1:0]           req_operation,
   input  logic [asid_pkg::POS_W-1:0]          req_position,
   input  logic signed [asid_pkg::VAL_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [asid_pkg::STATUS_W-1:0]       rsp_status,
   output logic [asid_pkg::INDEX_W-1:0]        rsp_found_index,
   output logic [asid_pkg::COUNT_W-1:0]        rsp_entry_count
);
   import asid_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LIN,
      S_BIN_RD,
      S_BIN_CMP,
      S_SHIFT,
      S_INS_WR,
      S_DONE
   } state_type;

   // list storage
   logic signed [VAL_W-1:0] mem [CAPACITY];
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic signed [VAL_W-1:0] mem_wr_data;
   logic signed [VAL_W-1:0] rd_data_ff;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   op_type                  op_ff, op_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic [IDX_W-1:0]        pos_idx_ff, pos_idx_in;
   logic [IDX_W-1:0]        sh_idx_ff, sh_idx_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic                    pend_ff, pend_in;
   logic [IDX_W-1:0]        pend_addr_ff, pend_addr_in;
   logic signed [CNT_W:0]   lo_ff, lo_in;
   logic signed [CNT_W:0]   hi_ff, hi_in;
   logic [IDX_W-1:0]        mid_ff, mid_in;
   status_type              status_ff, status_in;
   logic [IDX_W-1:0]        index_ff, index_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]      rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]        pos_ext;
   logic [CMP_W-1:0]        cnt_ext;
   logic [CMP_W-1:0]        pos_m1;
   logic [CMP_W-1:0]        cnt_m1;
   logic [CMP_W-1:0]        ins_rem;
   logic [CMP_W-1:0]        del_rem;
   logic signed [CNT_W:0]   mid;
   logic signed [CNT_W:0]   mid_ext;
   logic [IDX_W+INDEX_W-1:0] index_wide;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   assign pos_ext    = CMP_W'(req_position);
   assign cnt_ext    = CMP_W'(count_ff);
   assign pos_m1     = pos_ext - CMP_W'(1);
   assign cnt_m1     = cnt_ext - CMP_W'(1);
   assign ins_rem    = cnt_ext + CMP_W'(1) - pos_ext;
   assign del_rem    = cnt_ext - pos_ext;
   assign mid        = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign mid_ext    = $signed((CNT_W+1)'(mid_ff));
   assign index_wide = (IDX_W+INDEX_W)'(index_ff);
   assign count_wide = (CNT_W+COUNT_W)'(count_ff);

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_idx_in    = pos_idx_ff;
      sh_idx_in     = sh_idx_ff;
      rem_in        = rem_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = sh_idx_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pend_addr_ff;
      mem_wr_data   = rd_data_ff;

      // drop the result beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in      = op_type'(req_operation);
               val_in     = req_value;
               pos_idx_in = pos_m1[IDX_W-1:0];
               status_in  = ST_DONE;
               index_in   = '0;
               pend_in    = 1'b0;
               unique case (op_type'(req_operation))
                  OP_LINEAR: begin
                     sh_idx_in = '0;
                     rem_in    = count_ff;
                     state_in  = S_LIN;
                  end
                  OP_BINARY: begin
                     lo_in    = '0;
                     hi_in    = $signed({1'b0, count_ff}) - (CNT_W+1)'(1);
                     state_in = S_BIN_RD;
                  end
                  OP_INSERT: begin
                     priority if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
                        status_in = ST_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        sh_idx_in = cnt_m1[IDX_W-1:0];
                        rem_in    = ins_rem[CNT_W-1:0];
                        state_in  = S_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     priority if (pos_ext == '0 || pos_ext > cnt_ext) begin
                        status_in = ST_BAD_POS;
                        state_in  = S_DONE;
                     end else begin
                        sh_idx_in = pos_ext[IDX_W-1:0];
                        rem_in    = del_rem[CNT_W-1:0];
                        state_in  = S_SHIFT;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // one read a cycle, compare the previous read's data
         S_LIN: begin
            if (rem_ff != '0) begin
               mem_rd_en    = 1'b1;
               sh_idx_in    = sh_idx_ff + IDX_W'(1);
               rem_in       = rem_ff - CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = sh_idx_ff;
            end else begin
               pend_in = 1'b0;
            end
            priority if (pend_ff && rd_data_ff == val_ff) begin
               index_in = pend_addr_ff;
               pend_in  = 1'b0;
               state_in = S_DONE;
            end else if (!pend_ff && rem_ff == '0) begin
               status_in = ST_NOT_FOUND;
               index_in  = '0;
               state_in  = S_DONE;
            end else begin
               state_in = S_LIN;
            end
         end

         S_BIN_RD: begin
            if (lo_ff <= hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid[IDX_W-1:0];
               mid_in      = mid[IDX_W-1:0];
               state_in    = S_BIN_CMP;
            end else begin
               status_in = ST_NOT_FOUND;
               index_in  = '0;
               state_in  = S_DONE;
            end
         end

         S_BIN_CMP: begin
            priority if (rd_data_ff == val_ff) begin
               index_in = mid_ff;
               state_in = S_DONE;
            end else if (rd_data_ff < val_ff) begin
               lo_in    = mid_ext + (CNT_W+1)'(1);
               state_in = S_BIN_RD;
            end else begin
               hi_in    = mid_ext - (CNT_W+1)'(1);
               state_in = S_BIN_RD;
            end
         end

         // read one entry ahead, write it back one slot over in the next cycle
         S_SHIFT: begin
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end
            if (rem_ff != '0) begin
               mem_rd_en = 1'b1;
               rem_in    = rem_ff - CNT_W'(1);
               pend_in   = 1'b1;
               if (op_ff == OP_INSERT) begin
                  pend_addr_in = sh_idx_ff + IDX_W'(1);
                  sh_idx_in    = sh_idx_ff - IDX_W'(1);
               end else begin
                  pend_addr_in = sh_idx_ff - IDX_W'(1);
                  sh_idx_in    = sh_idx_ff + IDX_W'(1);
               end
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (op_ff == OP_INSERT) begin
                     state_in = S_INS_WR;
                  end else begin
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_DONE;
                  end
               end
            end
         end

         S_INS_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_idx_ff;
            mem_wr_data = val_ff;
            count_in    = count_ff + CNT_W'(1);
            state_in    = S_DONE;
         end

         // hold until the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_index_in  = index_wide[INDEX_W-1:0];
               rsp_count_in  = count_wide[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_idx_ff    <= pos_idx_in;
      sh_idx_ff     <= sh_idx_in;
      rem_ff        <= rem_in;
      pend_addr_ff  <= pend_addr_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
